@@ src/lfu_pkg.sv @@
// Package for the LFU cache with age expiry: command codes and the result payload type.
// No dependencies; the interfaces and all modules of the cache import it.
package lfu_pkg;

    localparam logic [2:0] CMD_GET      = 3'd0;
    localparam logic [2:0] CMD_PUT      = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_TICK     = 3'd4;
    localparam logic [2:0] CMD_MAINTAIN = 3'd5;

    localparam logic [1:0] CFG_MAX_ITEMS = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd1;
    localparam logic [1:0] CFG_EVICT_EN  = 2'd2;
    localparam logic [1:0] CFG_MAX_AGE   = 2'd3;

    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [31:0] value_handle;
        logic [15:0] value_size;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] value_out;
        logic        accepted;
        logic [6:0]  item_count;
        logic [31:0] bytes_used;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } rsp_t;

    // Saturating increment.
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

@@ src/lfu_if.sv @@
// Valid/ready channel interfaces for the cache request and result streams.
// Depends on lfu_pkg.
interface lfu_req_if;
    import lfu_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
    import lfu_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/lfu_ttl_keyed_cache.sv @@
// Top level of the keyed LFU cache with age expiry: sequencer, entry memory, outputs.
// Depends on lfu_pkg and lfu_if.
//
//  channel  | role  | payload
//  req      | sink  | command, key, value_handle, value_size
//  rsp      | src   | hit, value_out, accepted, item_count, bytes_used, totals
//  cfg      | write | cfg_we, cfg_index, cfg_data
//
// Get and remove run the key match scan; put and maintain may run the expiry sweep
// and least-used search, and put also the key match and free slot searches. Each scan
// walks the entry memory one slot a cycle through its single read port. Clear, tick
// and unknown codes run no scan. Reset empties the cache at once via the valid bits.
// While a result waits on rsp the block takes no request.
module lfu_ttl_keyed_cache #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lfu_req_if.sink     req,
    lfu_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lfu_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;  // key match scan
    localparam logic [3:0] S_SWEEP  = 4'd2;  // expiry sweep
    localparam logic [3:0] S_LFU    = 4'd3;  // least-used search
    localparam logic [3:0] S_DECIDE = 4'd4;  // put budget checks
    localparam logic [3:0] S_FREE   = 4'd5;  // free slot search
    localparam logic [3:0] S_DROP   = 4'd6;  // drop a slot read back
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_GETCHK = 4'd10;

    // Put phases (what the least-used search is for).
    localparam logic [1:0] PH_MAINT = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_BYTES = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [31:0]         handle;
        logic [15:0]         size;
        logic [31:0]         uses;
        logic [31:0]         stamp;
    } ent_t;

    // Configuration.
    logic [6:0]  max_items_reg;
    logic [31:0] max_bytes_reg;
    logic        evict_en_reg;
    logic [31:0] max_age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_items_reg <= 7'd64;
            max_bytes_reg <= 32'd1048576;
            evict_en_reg  <= 1'b1;
            max_age_reg   <= 32'd1000000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ITEMS: max_items_reg <= cfg_data[6:0];
                CFG_MAX_BYTES: max_bytes_reg <= cfg_data;
                CFG_EVICT_EN:  evict_en_reg  <= cfg_data[0];
                CFG_MAX_AGE:   max_age_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Entry memory, one read and one write port.
    ent_t mem [CAPACITY];
    ent_t rd_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    ent_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    logic [CAPACITY-1:0] valid_reg, valid_next;

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;     // address issued last cycle
    logic          rdv_reg, rdv_next;     // rd_reg holds data for idx_reg
    logic [AW-1:0] pidx_reg;              // slot in rd_reg
    logic [1:0]    phase_reg, phase_next;
    req_t          cur_reg, cur_next;
    logic [31:0]   now_reg, now_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   bytes_reg, bytes_next;
    logic [31:0]   hits_reg, hits_next, miss_reg, miss_next, evs_reg, evs_next;
    logic          found_reg, found_next;
    logic [AW-1:0] fslot_reg, fslot_next;
    logic          bv_reg, bv_next;       // best candidate valid
    logic [AW-1:0] bslot_reg, bslot_next;
    logic [31:0]   buses_reg, buses_next, bage_reg, bage_next;
    logic          hit_reg, hit_next, acc_reg, acc_next;
    logic [31:0]   vout_reg, vout_next;
    logic          dropcnt_reg, dropcnt_next; // drop counts as eviction
    logic [3:0]    ret_reg, ret_next;      // state after a drop
    rsp_t          out_reg, out_next;
    logic          ov_reg, ov_next;

    logic [KEY_BITS-1:0] ckey;
    assign ckey = KEY_BITS'(cur_reg.key);

    logic [CW-1:0] limit;
    assign limit = (32'(max_items_reg) < CAPACITY) ? CW'(max_items_reg) : CW'(CAPACITY);

    logic [31:0] age;
    assign age = now_reg - rd_reg.stamp;
    logic expd;
    assign expd = age >= max_age_reg;
    logic rvalid;
    assign rvalid = valid_reg[pidx_reg];

    logic [32:0] bsum;
    assign bsum = {1'b0, bytes_reg} + {17'd0, cur_reg.value_size};
    logic bytes_over;
    assign bytes_over = bsum > {1'b0, max_bytes_reg};

    assign req.ready = (state_reg == S_IDLE) && !ov_reg;
    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        rdv_next = 1'b0;
        phase_next = phase_reg;
        cur_next = cur_reg;
        now_next = now_reg;
        cnt_next = cnt_reg;
        bytes_next = bytes_reg;
        hits_next = hits_reg;
        miss_next = miss_reg;
        evs_next = evs_reg;
        found_next = found_reg;
        fslot_next = fslot_reg;
        bv_next = bv_reg;
        bslot_next = bslot_reg;
        buses_next = buses_reg;
        bage_next = bage_reg;
        hit_next = hit_reg;
        acc_next = acc_reg;
        vout_next = vout_reg;
        dropcnt_next = dropcnt_reg;
        ret_next = ret_reg;
        out_next = out_reg;
        ov_next = ov_reg;
        valid_next = valid_reg;
        rd_addr = idx_reg;
        wr_en = 1'b0;
        wr_addr = fslot_reg;
        wr_data = rd_reg;

        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && !ov_reg)
                begin
                    cur_next = req.data;
                    hit_next = 1'b0;
                    acc_next = 1'b0;
                    vout_next = '0;
                    found_next = 1'b0;
                    idx_next = '0;
                    rd_addr = '0;
                    case (req.data.command)
                        CMD_GET, CMD_REMOVE:
                        begin
                            rdv_next = 1'b1;
                            state_next = S_FIND;
                        end
                        CMD_PUT, CMD_MAINTAIN:
                        begin
                            phase_next = PH_MAINT;
                            if (req.data.command == CMD_MAINTAIN ||
                                (cnt_reg >= limit) || (bytes_reg >= max_bytes_reg))
                            begin
                                rdv_next = 1'b1;
                                state_next = S_SWEEP;
                            end
                            else
                                state_next = S_DECIDE;
                        end
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                            cnt_next = '0;
                            bytes_next = '0;
                            state_next = S_DONE;
                        end
                        CMD_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            S_FIND:
            begin
                // rd_reg holds slot pidx_reg; first match wins.
                if (rdv_reg && rvalid && rd_reg.key == ckey && !found_next)
                begin
                    found_next = 1'b1;
                    fslot_next = pidx_reg;
                end
                if (rdv_reg && 32'(pidx_reg) == CAPACITY - 1)
                begin
                    if (cur_reg.command == CMD_PUT)
                    begin
                        if (found_next)
                        begin
                            // replace: give back old bytes, then hunt nothing
                            valid_next[fslot_next] = 1'b0;
                            cnt_next = cnt_reg - CW'(1);
                            bytes_next = (bytes_reg >= 32'(rd_reg.size) && pidx_reg == fslot_next)
                                ? bytes_reg - 32'(rd_reg.size) : '0;
                            // size read back in S_DROP path when not the last slot
                            if (pidx_reg == fslot_next)
                                state_next = S_WRITE;
                            else
                            begin
                                rd_addr = fslot_next;
                                dropcnt_next = 1'b0;
                                ret_next = S_WRITE;
                                state_next = S_DROP;
                                valid_next[fslot_next] = 1'b1;
                                cnt_next = cnt_reg;
                                bytes_next = bytes_reg;
                            end
                        end
                        else
                        begin
                            idx_next = '0;
                            rd_addr = '0;
                            rdv_next = 1'b1;
                            state_next = S_FREE;
                        end
                    end
                    else if (found_next)
                    begin
                        rd_addr = fslot_next;
                        state_next = S_GETCHK;
                    end
                    else
                    begin
                        if (cur_reg.command == CMD_GET)
                            miss_next = sat_inc(miss_reg);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr = idx_next;
                    rdv_next = 1'b1;
                end
            end

            S_GETCHK:
            begin
                // rd_reg holds the matched entry.
                if (cur_reg.command == CMD_REMOVE)
                begin
                    hit_next = 1'b1;
                    valid_next[fslot_reg] = 1'b0;
                    bytes_next = (bytes_reg >= 32'(rd_reg.size))
                        ? bytes_reg - 32'(rd_reg.size) : '0;
                    if (cnt_reg != '0)
                        cnt_next = cnt_reg - CW'(1);
                end
                else if (!expd)
                begin
                    hit_next = 1'b1;
                    vout_next = rd_reg.handle;
                    hits_next = sat_inc(hits_reg);
                    wr_en = 1'b1;
                    wr_addr = fslot_reg;
                    wr_data = rd_reg;
                    wr_data.uses = sat_inc(rd_reg.uses);
                    wr_data.stamp = now_reg;
                end
                else
                begin
                    miss_next = sat_inc(miss_reg);
                    valid_next[fslot_reg] = 1'b0;
                    bytes_next = (bytes_reg >= 32'(rd_reg.size))
                        ? bytes_reg - 32'(rd_reg.size) : '0;
                    if (cnt_reg != '0)
                        cnt_next = cnt_reg - CW'(1);
                end
                state_next = S_DONE;
            end

            S_SWEEP:
            begin
                if (rdv_reg && rvalid && expd)
                begin
                    valid_next[pidx_reg] = 1'b0;
                    bytes_next = (bytes_reg >= 32'(rd_reg.size))
                        ? bytes_reg - 32'(rd_reg.size) : '0;
                    if (cnt_reg != '0)
                        cnt_next = cnt_reg - CW'(1);
                    evs_next = sat_inc(evs_reg);
                end
                if (rdv_reg && 32'(pidx_reg) == CAPACITY - 1)
                begin
                    // over-budget test on the updated totals
                    if ((cnt_next >= limit) || (bytes_next >= max_bytes_reg))
                    begin
                        phase_next = PH_MAINT;
                        bv_next = 1'b0;
                        idx_next = '0;
                        rd_addr = '0;
                        rdv_next = 1'b1;
                        state_next = S_LFU;
                    end
                    else
                        state_next = (cur_reg.command == CMD_PUT) ? S_DECIDE : S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr = idx_next;
                    rdv_next = 1'b1;
                end
            end

            S_LFU:
            begin
                if (rdv_reg && rvalid && (!bv_next || rd_reg.uses < buses_reg ||
                    (rd_reg.uses == buses_reg && age > bage_reg)))
                begin
                    bv_next = 1'b1;
                    bslot_next = pidx_reg;
                    buses_next = rd_reg.uses;
                    bage_next = age;
                end
                if (rdv_reg && 32'(pidx_reg) == CAPACITY - 1)
                begin
                    if (bv_next)
                    begin
                        rd_addr = bslot_next;
                        dropcnt_next = 1'b1;
                        state_next = S_DROP;
                        case (phase_reg)
                            PH_MAINT:
                                ret_next = (cur_reg.command == CMD_PUT) ? S_DECIDE : S_DONE;
                            PH_COUNT: ret_next = S_DECIDE;
                            default:  ret_next = S_DECIDE;
                        endcase
                    end
                    else
                    begin
                        state_next = (phase_reg == PH_MAINT && cur_reg.command != CMD_PUT)
                            ? S_DONE : S_DECIDE;
                    end
                    if (phase_reg == PH_BYTES)
                        phase_next = PH_BYTES; // decide rechecks; fails if still over
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr = idx_next;
                    rdv_next = 1'b1;
                end
            end

            S_DROP:
            begin
                // rd_reg holds the slot to drop (bslot or fslot).
                if (dropcnt_reg)
                begin
                    valid_next[bslot_reg] = 1'b0;
                    evs_next = sat_inc(evs_reg);
                end
                else
                    valid_next[fslot_reg] = 1'b0;
                bytes_next = (bytes_reg >= 32'(rd_reg.size))
                    ? bytes_reg - 32'(rd_reg.size) : '0;
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - CW'(1);
                state_next = ret_reg;
            end

            S_DECIDE:
            begin
                // Put budget checks, in order; phase says which are done.
                if (phase_reg == PH_MAINT && cnt_reg >= limit)
                begin
                    phase_next = PH_COUNT;
                    if (!evict_en_reg)
                        state_next = S_DONE;
                    else
                    begin
                        bv_next = 1'b0;
                        idx_next = '0;
                        rd_addr = '0;
                        rdv_next = 1'b1;
                        state_next = S_LFU;
                    end
                end
                else if (phase_reg != PH_BYTES && bytes_over)
                begin
                    phase_next = PH_BYTES;
                    if (!evict_en_reg)
                        state_next = S_DONE;
                    else
                    begin
                        bv_next = 1'b0;
                        idx_next = '0;
                        rd_addr = '0;
                        rdv_next = 1'b1;
                        state_next = S_LFU;
                    end
                end
                else if (phase_reg == PH_BYTES && bytes_over)
                    state_next = S_DONE;
                else
                begin
                    found_next = 1'b0;
                    idx_next = '0;
                    rd_addr = '0;
                    rdv_next = 1'b1;
                    state_next = S_FIND;
                end
            end

            S_FREE:
            begin
                if (rdv_reg && !rvalid && !found_next)
                begin
                    found_next = 1'b1;
                    fslot_next = pidx_reg;
                end
                if (rdv_reg && 32'(pidx_reg) == CAPACITY - 1)
                    state_next = found_next ? S_WRITE : S_DONE;
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr = idx_next;
                    rdv_next = 1'b1;
                end
            end

            S_WRITE:
            begin
                wr_en = 1'b1;
                wr_addr = fslot_reg;
                wr_data.key = ckey;
                wr_data.handle = cur_reg.value_handle;
                wr_data.size = cur_reg.value_size;
                wr_data.uses = '0;
                wr_data.stamp = now_reg;
                valid_next[fslot_reg] = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                bytes_next = ({1'b0, bytes_reg} + {17'd0, cur_reg.value_size} > {1'b0, SAT_MAX})
                    ? SAT_MAX : bytes_reg + 32'(cur_reg.value_size);
                acc_next = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                out_next.hit = hit_reg;
                out_next.value_out = vout_reg;
                out_next.accepted = acc_reg;
                out_next.item_count = 7'(cnt_reg);
                out_next.bytes_used = bytes_reg;
                out_next.hit_total = hits_reg;
                out_next.miss_total = miss_reg;
                out_next.evict_total = evs_reg;
                ov_next = 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
                state_next = S_IDLE;

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            rdv_reg <= 1'b0;
            pidx_reg <= '0;
            phase_reg <= PH_MAINT;
            now_reg <= '0;
            cnt_reg <= '0;
            bytes_reg <= '0;
            hits_reg <= '0;
            miss_reg <= '0;
            evs_reg <= '0;
            valid_reg <= '0;
            ov_reg <= 1'b0;
            found_reg <= 1'b0;
            bv_reg <= 1'b0;
            dropcnt_reg <= 1'b0;
            ret_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            rdv_reg <= rdv_next;
            pidx_reg <= rd_addr;
            phase_reg <= phase_next;
            now_reg <= now_next;
            cnt_reg <= cnt_next;
            bytes_reg <= bytes_next;
            hits_reg <= hits_next;
            miss_reg <= miss_next;
            evs_reg <= evs_next;
            valid_reg <= valid_next;
            ov_reg <= ov_next;
            found_reg <= found_next;
            bv_reg <= bv_next;
            dropcnt_reg <= dropcnt_next;
            ret_reg <= ret_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        fslot_reg <= fslot_next;
        bslot_reg <= bslot_next;
        buses_reg <= buses_next;
        bage_reg <= bage_next;
        hit_reg <= hit_next;
        acc_reg <= acc_next;
        vout_reg <= vout_next;
        out_reg <= out_next;
    end

endmodule
